// ===== rtl/stable_priority_process_queue_defines.svh =====
// Assertion macros shared by the stable priority process queue RTL.
`ifndef STABLE_PRIORITY_PROCESS_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_PROCESS_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the stable priority process queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int ID_BITS_DEF       = 8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } spq_status_t;

  // Operation broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int INDEX         = 0,
  parameter int CNT_BITS      = 5,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int ID_BITS       = spq_pkg::ID_BITS_DEF
) (
  input  wire                         clk,
  input  spq_pkg::spq_ctl_t           ctl,
  input  wire  [CNT_BITS-1:0]         count,
  input  wire  [PRIORITY_BITS-1:0]    new_pri,
  input  wire  [ID_BITS-1:0]          new_id,
  input  wire                         left_keep,
  input  wire  [PRIORITY_BITS-1:0]    left_pri,
  input  wire  [ID_BITS-1:0]          left_id,
  input  wire  [PRIORITY_BITS-1:0]    right_pri,
  input  wire  [ID_BITS-1:0]          right_id,
  output logic                        keep,
  output logic [PRIORITY_BITS-1:0]    pri_q,
  output logic [ID_BITS-1:0]          id_q
);

  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  logic                     occupied;

  assign occupied = (count > CNT_BITS'(INDEX));
  // An occupied slot whose priority is at least the new one stays ahead of it.
  assign keep     = occupied && (pri_r >= new_pri);

  always_comb begin
    pri_nxt = pri_r;
    id_nxt  = id_r;
    if (ctl.push) begin
      if (!keep) begin
        if (left_keep) begin
          pri_nxt = new_pri;
          id_nxt  = new_id;
        end else begin
          pri_nxt = left_pri;
          id_nxt  = left_id;
        end
      end
    end else if (ctl.pop) begin
      pri_nxt = right_pri;
      id_nxt  = right_id;
    end
  end

  always_ff @(posedge clk) begin
    pri_r <= pri_nxt;
    id_r  <= id_nxt;
  end

  assign pri_q = pri_r;
  assign id_q  = id_r;

endmodule

`default_nettype wire

// ===== rtl/stable_priority_process_queue.sv =====
// Top level of the stable priority process queue built as a chain of slot cells.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    in_cmd, in_new_priority, in_new_id
//   out      out_valid / out_ready  out_status, out_priority, out_id, out_occupancy
//
// Every cell compares its priority against the new one in parallel and the
// whole chain shifts by at most one slot per beat. The result sits in an
// output register; a new beat is taken whenever that register is empty or
// being drained, so one item per cycle is sustained.
// Synchronous active-low reset empties the queue and the output register.
// A stall on out_ready holds the result and blocks in_ready.
`timescale 1ns / 1ps
`default_nettype none

`include "stable_priority_process_queue_defines.svh"

module stable_priority_process_queue #(
  parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int ID_BITS       = spq_pkg::ID_BITS_DEF,
  localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_cmd,
  input  wire  [PRIORITY_BITS-1:0] in_new_priority,
  input  wire  [ID_BITS-1:0]       in_new_id,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [1:0]               out_status,
  output logic [PRIORITY_BITS-1:0] out_priority,
  output logic [ID_BITS-1:0]       out_id,
  output logic [CNT_BITS-1:0]      out_occupancy
);

  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [CNT_BITS-1:0] ONE_COUNT  = CNT_BITS'(1);

  logic [CNT_BITS-1:0]      count_r, count_nxt;
  logic                     out_valid_r;
  spq_pkg::spq_status_t     status_r, status_nxt;
  logic [PRIORITY_BITS-1:0] opri_r, opri_nxt;
  logic [ID_BITS-1:0]       oid_r, oid_nxt;
  logic [CNT_BITS-1:0]      occ_r;

  logic                     in_fire;
  logic                     is_full, is_empty;
  spq_pkg::spq_ctl_t        ctl;

  logic [QUEUE_DEPTH-1:0]   keep_w;
  logic [PRIORITY_BITS-1:0] pri_w [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       id_w  [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count_r == FULL_COUNT);
  assign is_empty = (count_r == '0);

  assign ctl.push = in_fire && (in_cmd == spq_pkg::CMD_PUSH) && !is_full;
  assign ctl.pop  = in_fire && (in_cmd == spq_pkg::CMD_POP) && !is_empty;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                     lk;
      logic [PRIORITY_BITS-1:0] lp, rp;
      logic [ID_BITS-1:0]       li, ri;

      if (gi == 0) begin : g_head
        // The head has nothing in front of it, so a new entry may always land here.
        assign lk = 1'b1;
        assign lp = in_new_priority;
        assign li = in_new_id;
      end else begin : g_body
        assign lk = keep_w[gi-1];
        assign lp = pri_w[gi-1];
        assign li = id_w[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign rp = pri_w[gi];
        assign ri = id_w[gi];
      end else begin : g_mid
        assign rp = pri_w[gi+1];
        assign ri = id_w[gi+1];
      end

      spq_cell #(
        .INDEX         (gi),
        .CNT_BITS      (CNT_BITS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .ID_BITS       (ID_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .new_pri   (in_new_priority),
        .new_id    (in_new_id),
        .left_keep (lk),
        .left_pri  (lp),
        .left_id   (li),
        .right_pri (rp),
        .right_id  (ri),
        .keep      (keep_w[gi]),
        .pri_q     (pri_w[gi]),
        .id_q      (id_w[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + ONE_COUNT;
    end else if (ctl.pop) begin
      count_nxt = count_r - ONE_COUNT;
    end
  end

  always_comb begin
    status_nxt = spq_pkg::ST_PUSHED;
    opri_nxt   = '0;
    oid_nxt    = '0;
    case (in_cmd)
      spq_pkg::CMD_PUSH: begin
        status_nxt = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_PUSHED;
      end
      spq_pkg::CMD_POP: begin
        if (is_empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          status_nxt = spq_pkg::ST_POPPED;
          opri_nxt   = pri_w[0];
          oid_nxt    = id_w[0];
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_PUSHED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      opri_r   <= opri_nxt;
      oid_r    <= oid_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_priority  = opri_r;
  assign out_id        = oid_r;
  assign out_occupancy = occ_r;

  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= FULL_COUNT)
  `SPQ_ASSERT_SAME(a_tail_keep_full, keep_w[QUEUE_DEPTH-1], is_full)
  `SPQ_ASSERT_NEXT(a_pop_shrinks, ctl.pop, count_r == $past(count_r) - ONE_COUNT)
  `SPQ_ASSERT_NEXT(a_beat_registered, in_fire, out_valid_r && (occ_r == count_r))
  `SPQ_ASSERT_SAME(a_idle_payload_zero,
                   out_valid_r && (status_r != spq_pkg::ST_POPPED),
                   (opri_r == '0) && (oid_r == '0))

endmodule

`default_nettype wire
